>>> rtl/core/crt_pkg.sv
// Shared types and codes for the capability rights table.
package crt_pkg;

  typedef enum logic [2:0] {
    CMD_QUERY   = 3'd0,
    CMD_GRANT   = 3'd1,
    CMD_REVOKE  = 3'd2,
    CMD_INHERIT = 3'd3,
    CMD_CLEAR   = 3'd4
  } crt_cmd_t;

  typedef enum logic [1:0] {
    REG_KERNEL_SUBJECT  = 2'd0,
    REG_ADMIN_MASK      = 2'd1,
    REG_DEFAULT_SUBJECT = 2'd2,
    REG_DEFAULT_RIGHTS  = 2'd3
  } crt_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUBJ,
    ST_PAR,
    ST_EXEC
  } crt_state_t;

  localparam int unsigned RIGHTS_W = 64;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;

endpackage

>>> rtl/core/capability_rights_table.sv
// Capability rights table: per-subject 64-bit rights masks with a change counter.
// A command is taken when start is high and busy is low; busy then stays high
// through the SUBJ, PAR and EXEC states while the actor, subject and parent entries
// are read one after the other through the single read port of the table memory.
// The result shows with out_valid in the cycle after EXEC, when busy is low again.
// A new command can be taken in the same cycle the result is shown, but not before
// the last command's result. The result cannot be held off: whoever issues commands
// must take it in the cycle that out_valid marks. Configuration writes are meant for
// times when no command is in flight.
module capability_rights_table #(
  parameter int unsigned NUM_SUBJECTS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [crt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crt_pkg::RIGHTS_W-1:0]   cfg_wdata,
  input  logic                           start,
  output logic                           busy,
  input  logic [crt_pkg::CMD_W-1:0]      in_cmd,
  input  logic [crt_pkg::IDX_W-1:0]      in_actor,
  input  logic [crt_pkg::IDX_W-1:0]      in_subject,
  input  logic [crt_pkg::IDX_W-1:0]      in_parent,
  input  logic [crt_pkg::RIGHTS_W-1:0]   in_rights,
  output logic                           out_valid,
  output logic                           out_status,
  output logic                           out_allowed,
  output logic [crt_pkg::RIGHTS_W-1:0]   out_subject_rights,
  output logic [crt_pkg::RIGHTS_W-1:0]   out_generation
);
  import crt_pkg::*;

  localparam int unsigned IW = (NUM_SUBJECTS > 1) ? $clog2(NUM_SUBJECTS) : 1;
  localparam logic [IDX_W:0] NUM_SUBJ_V = (IDX_W+1)'(NUM_SUBJECTS);

  // Configuration registers
  logic [IDX_W-1:0]    kernel_subject_r;
  logic [RIGHTS_W-1:0] admin_mask_r;
  logic [IDX_W-1:0]    default_subject_r;
  logic [RIGHTS_W-1:0] default_rights_r;

  // Table storage
  logic [RIGHTS_W-1:0] mem [NUM_SUBJECTS];
  logic [RIGHTS_W-1:0] rd_data_r;
  logic [IW-1:0]       rd_addr;
  logic                mem_we;
  logic [RIGHTS_W-1:0] mem_wdata;
  logic [NUM_SUBJECTS-1:0] written_r;

  crt_state_t state_r, state_nxt;

  // Latched command
  crt_cmd_t            cmd_r;
  logic [IDX_W-1:0]    actor_r;
  logic [IDX_W-1:0]    subject_r;
  logic [IDX_W-1:0]    parent_r;
  logic [RIGHTS_W-1:0] rights_r;
  logic [RIGHTS_W-1:0] actor_eff_r;
  logic [RIGHTS_W-1:0] subj_eff_r;
  logic [RIGHTS_W-1:0] gen_r;

  logic                accept;
  logic                exec_en;

  // Execution results
  logic                subj_ok, actor_priv, protect, parent_ok;
  logic [RIGHTS_W-1:0] parent_eff;
  logic                fail, allowed;

  logic                out_valid_r, out_status_r, out_allowed_r;
  logic [RIGHTS_W-1:0] out_subject_rights_r;

  function automatic logic in_rng(input logic [IDX_W-1:0] idx);
    return {1'b0, idx} < NUM_SUBJ_V;
  endfunction

  function automatic logic wr_bit(input logic [IDX_W-1:0] idx);
    return in_rng(idx) && written_r[idx[IW-1:0]];
  endfunction

  // Effective mask: stored value once written, else the kernel and default rules.
  function automatic logic [RIGHTS_W-1:0] eff_mask(input logic [IDX_W-1:0] idx,
                                                   input logic [RIGHTS_W-1:0] data);
    logic [RIGHTS_W-1:0] res;
    if (wr_bit(idx)) begin
      res = data;
    end else if (idx == kernel_subject_r) begin
      res = '1;
    end else if (idx == default_subject_r) begin
      res = default_rights_r;
    end else begin
      res = '0;
    end
    return res;
  endfunction

  assign accept = start && !busy;

  // Configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_subject_r  <= '0;
      admin_mask_r      <= RIGHTS_W'(1);
      default_subject_r <= IDX_W'(1);
      default_rights_r  <= '0;
    end else if (cfg_we) begin
      unique case (crt_reg_t'(cfg_index))
        REG_KERNEL_SUBJECT:  kernel_subject_r  <= cfg_wdata[IDX_W-1:0];
        REG_ADMIN_MASK:      admin_mask_r      <= cfg_wdata;
        REG_DEFAULT_SUBJECT: default_subject_r <= cfg_wdata[IDX_W-1:0];
        REG_DEFAULT_RIGHTS:  default_rights_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SUBJ;
      ST_SUBJ: state_nxt = ST_PAR;
      ST_PAR:  state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs and read address sequencing
  always_comb begin
    busy    = 1'b1;
    exec_en = 1'b0;
    rd_addr = subject_r[IW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        busy    = 1'b0;
        rd_addr = in_actor[IW-1:0];
      end
      ST_SUBJ: rd_addr = subject_r[IW-1:0];
      ST_PAR:  rd_addr = parent_r[IW-1:0];
      ST_EXEC: exec_en = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= crt_cmd_t'(in_cmd);
      actor_r   <= in_actor;
      subject_r <= in_subject;
      parent_r  <= in_parent;
      rights_r  <= in_rights;
    end
    if (state_r == ST_SUBJ) begin
      actor_eff_r <= eff_mask(actor_r, rd_data_r);
    end
    if (state_r == ST_PAR) begin
      subj_eff_r <= eff_mask(subject_r, rd_data_r);
    end
  end

  // Table memory: one write and one registered read per cycle. The write lands
  // at the end of a command, before the next command issues its first read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[subject_r[IW-1:0]] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (mem_we) begin
      written_r[subject_r[IW-1:0]] <= 1'b1;
    end
  end

  // Command evaluation in the last cycle, with the parent entry on the read port.
  always_comb begin
    subj_ok     = in_rng(subject_r);
    actor_priv  = in_rng(actor_r) && ((actor_eff_r & admin_mask_r) != '0);
    protect     = (subject_r == kernel_subject_r);
    parent_ok   = in_rng(parent_r);
    parent_eff  = eff_mask(parent_r, rd_data_r);
    fail        = 1'b1;
    allowed     = 1'b0;
    mem_wdata   = '0;
    case (cmd_r)
      CMD_QUERY: begin
        fail    = !subj_ok;
        allowed = subj_ok && ((subj_eff_r & rights_r) == rights_r);
      end
      CMD_GRANT: begin
        fail      = !(subj_ok && actor_priv);
        mem_wdata = subj_eff_r | rights_r;
      end
      CMD_REVOKE: begin
        fail      = !(subj_ok && actor_priv && !protect);
        mem_wdata = subj_eff_r & ~rights_r;
      end
      CMD_INHERIT: begin
        fail      = !(subj_ok && actor_priv && !protect && parent_ok);
        mem_wdata = parent_eff;
      end
      CMD_CLEAR: begin
        fail      = !(subj_ok && actor_priv && !protect);
        mem_wdata = '0;
      end
      default: fail = 1'b1;
    endcase
    mem_we = exec_en && !fail && (cmd_r != CMD_QUERY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r       <= RIGHTS_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= exec_en;
      if (mem_we) begin
        gen_r <= gen_r + RIGHTS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      out_status_r  <= fail;
      out_allowed_r <= allowed;
      if (!subj_ok) begin
        out_subject_rights_r <= '0;
      end else if (mem_we) begin
        out_subject_rights_r <= mem_wdata;
      end else begin
        out_subject_rights_r <= subj_eff_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_allowed        = out_allowed_r;
  assign out_subject_rights = out_subject_rights_r;
  assign out_generation     = gen_r;

endmodule

>>> rtl/core/crt_checker.sv
// Port-level checks for the capability rights table, bound into capability_rights_table.
module crt_port_checks (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_status,
  input logic out_allowed
);

  // A taken command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command taken but block not busy afterwards");

  // A result only follows a cycle in which a command was in flight.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a command in flight");

  // A result strobe is never followed directly by another.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on two cycles in a row");

  // A granted check is never a rejected transaction.
  a_allowed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_allowed) |-> !out_status)
    else $error("allowed set on a rejected transaction");

endmodule

bind capability_rights_table crt_port_checks u_crt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_status  (out_status),
  .out_allowed (out_allowed)
);
